@@ rtl/xce_pkg.sv @@
// Package for the XML character escaper: widths, character codes,
// register indexes, the run type and the decimal digit helper.
// No dependencies.
package xce_pkg;

   localparam int CP_W    = 21;
   localparam int RUN_MAX = 6;
   localparam int IDX_W   = 3;
   localparam int LEN_W   = 3;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   typedef logic [CP_W-1:0] cp_type;

   // Characters used in the escaped runs
   localparam cp_type CH_QUOT = 21'h22;
   localparam cp_type CH_HASH = 21'h23;
   localparam cp_type CH_AMP  = 21'h26;
   localparam cp_type CH_APOS = 21'h27;
   localparam cp_type CH_ZERO = 21'h30;
   localparam cp_type CH_THREE = 21'h33;
   localparam cp_type CH_NINE = 21'h39;
   localparam cp_type CH_SEMI = 21'h3B;
   localparam cp_type CH_LT   = 21'h3C;
   localparam cp_type CH_GT   = 21'h3E;
   localparam cp_type CH_A    = 21'h61;
   localparam cp_type CH_G    = 21'h67;
   localparam cp_type CH_L    = 21'h6C;
   localparam cp_type CH_M    = 21'h6D;
   localparam cp_type CH_O    = 21'h6F;
   localparam cp_type CH_P    = 21'h70;
   localparam cp_type CH_Q    = 21'h71;
   localparam cp_type CH_T    = 21'h74;
   localparam cp_type CH_U    = 21'h75;

   // Control code ranges that become numeric references
   localparam cp_type CTL_ONE_HI   = 21'h8;
   localparam cp_type CTL_TWO_LO   = 21'hB;
   localparam cp_type CTL_TWO_HI   = 21'h1F;
   localparam cp_type CTL_TWO_SKIP = 21'hD;
   localparam cp_type CTL_THR_LO   = 21'h7F;
   localparam cp_type CTL_THR_HI   = 21'h9F;
   localparam cp_type CTL_THR_SKIP = 21'h85;

   typedef enum logic [0:0] {
      REG_ESC_QUOTE = 1'b0,
      REG_ESC_APOS  = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic escape_quote;
      logic escape_apostrophe;
   } cfg_type;

   typedef struct packed {
      logic [LEN_W-1:0]           len;
      logic [RUN_MAX-1:0][CP_W-1:0] chars;
   } run_type;

   // Split a value below 64 into decimal tens and ones
   function automatic logic [6:0] dec_split(input logic [5:0] v);
      logic [2:0] tens;
      logic [6:0] prod;
      logic [6:0] ones;
      if (v >= 6'd60) tens = 3'd6;
      else if (v >= 6'd50) tens = 3'd5;
      else if (v >= 6'd40) tens = 3'd4;
      else if (v >= 6'd30) tens = 3'd3;
      else if (v >= 6'd20) tens = 3'd2;
      else if (v >= 6'd10) tens = 3'd1;
      else tens = 3'd0;
      prod = 7'(tens) * 7'd10;
      ones = 7'(v) - prod;
      return {tens, ones[3:0]};
   endfunction

   function automatic cp_type digit_char(input logic [3:0] d);
      return CH_ZERO + CP_W'(d);
   endfunction

endpackage

@@ rtl/xce_req_if.sv @@
// Input channel: one character word per handshake.
// Depends on xce_pkg.
interface xce_req_if import xce_pkg::*;;
   logic   valid;
   logic   ready;
   cp_type code_point;
   logic   text_end;

   modport source (output valid, output code_point, output text_end, input ready);
   modport sink   (input valid, input code_point, input text_end, output ready);
endinterface

@@ rtl/xce_rsp_if.sv @@
// Result channel: one escaped character word per handshake.
// Depends on xce_pkg.
interface xce_rsp_if import xce_pkg::*;;
   logic   valid;
   logic   ready;
   cp_type out_char;
   logic   run_last;
   logic   text_done;

   modport source (output valid, output out_char, output run_last, output text_done,
                    input ready);
   modport sink   (input valid, input out_char, input run_last, input text_done,
                    output ready);
endinterface

@@ rtl/xce_csr.sv @@
// APB register block holding the quote and apostrophe escape enables.
// Depends on xce_pkg.
module xce_csr import xce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   reg_idx_type reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & (paddr[1:0] == 2'b00);
   assign reg_sel = reg_idx_type'(paddr[2]);

   // Update the addressed enable
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_ESC_QUOTE: cfg_in.escape_quote      = pwdata[0];
            REG_ESC_APOS:  cfg_in.escape_apostrophe = pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{escape_quote: 1'b1, escape_apostrophe: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed enable
   always_comb begin
      prdata = '0;
      case (reg_sel)
         REG_ESC_QUOTE: prdata[0] = cfg_ff.escape_quote;
         REG_ESC_APOS:  prdata[0] = cfg_ff.escape_apostrophe;
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/xce_escape.sv @@
// Combinational escape table: maps one code point to its run of 1 to 6
// characters. Depends on xce_pkg.
module xce_escape import xce_pkg::*; (
   input  cp_type  code,
   input  cfg_type cfg,
   output run_type run
);

   logic [6:0] two_dig;
   logic [6:0] thr_dig;
   logic [7:0] thr_low;
   logic       is_one;
   logic       is_two;
   logic       is_thr;

   // Digits of the two and three digit references
   assign thr_low = code[7:0] - 8'd100;
   assign two_dig = dec_split(code[5:0]);
   assign thr_dig = dec_split(thr_low[5:0]);

   assign is_one = code <= CTL_ONE_HI;
   assign is_two = (code >= CTL_TWO_LO) && (code <= CTL_TWO_HI) && (code != CTL_TWO_SKIP);
   assign is_thr = (code >= CTL_THR_LO) && (code <= CTL_THR_HI) && (code != CTL_THR_SKIP);

   // Pick the run
   always_comb begin
      run.len   = LEN_W'(1);
      run.chars = '0;
      run.chars[0] = code;
      if (code == CH_LT) begin
         run.len   = LEN_W'(4);
         run.chars[3:0] = {CH_SEMI, CH_T, CH_L, CH_AMP};
      end else if (code == CH_GT) begin
         run.len   = LEN_W'(4);
         run.chars[3:0] = {CH_SEMI, CH_T, CH_G, CH_AMP};
      end else if (code == CH_AMP) begin
         run.len   = LEN_W'(5);
         run.chars[4:0] = {CH_SEMI, CH_P, CH_M, CH_A, CH_AMP};
      end else if (code == CH_QUOT && cfg.escape_quote) begin
         run.len   = LEN_W'(6);
         run.chars = {CH_SEMI, CH_T, CH_O, CH_U, CH_Q, CH_AMP};
      end else if (code == CH_APOS && cfg.escape_apostrophe) begin
         run.len   = LEN_W'(5);
         run.chars[4:0] = {CH_SEMI, CH_NINE, CH_THREE, CH_HASH, CH_AMP};
      end else if (is_one) begin
         run.len   = LEN_W'(4);
         run.chars[3:0] = {CH_SEMI, digit_char(code[3:0]), CH_HASH, CH_AMP};
      end else if (is_two) begin
         run.len   = LEN_W'(5);
         run.chars[4:0] = {CH_SEMI, digit_char(two_dig[3:0]),
                           digit_char({1'b0, two_dig[6:4]}), CH_HASH, CH_AMP};
      end else if (is_thr) begin
         run.len   = LEN_W'(6);
         run.chars = {CH_SEMI, digit_char(thr_dig[3:0]),
                      digit_char({1'b0, thr_dig[6:4]}), digit_char(4'd1),
                      CH_HASH, CH_AMP};
      end
   end

endmodule

@@ rtl/xce_emit.sv @@
// Run register and serializer: holds one escaped run and sends it one
// character word per handshake. Depends on xce_pkg and xce_rsp_if.
module xce_emit import xce_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load_valid,
   input  run_type   load_run,
   input  logic      load_end,
   output logic      load_ready,
   xce_rsp_if.source rsp_ch
);

   logic             valid_ff;
   logic             valid_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   run_type          run_ff;
   run_type          run_in;
   logic             end_ff;
   logic             end_in;
   logic             last;
   logic             take;

   assign last       = idx_ff == (run_ff.len - LEN_W'(1));
   assign take       = valid_ff & rsp_ch.ready;
   assign load_ready = ~valid_ff | (take & last);

   // Advance through the run, reload at its end
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      run_in   = run_ff;
      end_in   = end_ff;
      if (load_ready) begin
         valid_in = load_valid;
         idx_in   = '0;
         run_in   = load_run;
         end_in   = load_end;
      end else if (take) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      end_ff <= end_in;
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.out_char  = run_ff.chars[idx_ff];
   assign rsp_ch.run_last  = last;
   assign rsp_ch.text_done = last & end_ff;

`ifndef SYNTH
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (LEN_W'(idx_ff) < run_ff.len))
      else $error("run index past run length");
   a_step: assert property (@(posedge clock) disable iff (reset)
      (take && !last) |=> (valid_ff && idx_ff == $past(idx_ff) + IDX_W'(1)))
      else $error("run did not advance by one word");
   a_single: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && run_ff.len == LEN_W'(1)) |-> rsp_ch.run_last)
      else $error("single word run not marked last");
`endif

endmodule

@@ rtl/xml_char_escaper_top.sv @@
// XML character escaper: one code point word in, 1 to 6 words out.
// An input word goes through the input register, then the run register.
// Throughput: one input word per cycle when each maps to one result word
// and output is ready; longer runs hold the input until their last word.
// Reset: synchronous, active high; clears both stages and sets both
// escape enables.
module xml_char_escaper_top import xce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   xce_req_if.sink           req_ch,
   xce_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type cfg;
   logic    in_valid_ff;
   logic    in_valid_in;
   cp_type  in_code_ff;
   logic    in_end_ff;
   logic    load_ready;
   logic    req_take;
   run_type esc_run;

   xce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Input register
   assign req_ch.ready = ~in_valid_ff | load_ready;
   assign req_take     = req_ch.valid & req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_code_ff <= req_ch.code_point;
         in_end_ff  <= req_ch.text_end;
      end
   end

   xce_escape u_escape (
      .code (in_code_ff),
      .cfg  (cfg),
      .run  (esc_run)
   );

   xce_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .load_run   (esc_run),
      .load_end   (in_end_ff),
      .load_ready (load_ready),
      .rsp_ch     (rsp_ch)
   );

`ifndef SYNTH
   a_no_done_midrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.run_last) |-> !rsp_ch.text_done)
      else $error("text done before end of run");
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !load_ready) |=> (in_valid_ff && $stable(in_code_ff)))
      else $error("input word lost while run register busy");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ch.ready)
      else $error("input blocked with empty input register");
`endif

endmodule
